// ===== rtl/core/mpa_pkg.sv =====
// Shared constants for the max pooling with argmax block.
// No dependencies.
package mpa_pkg;

	localparam int MAX_WIDTH_DEF    = 1024;
	localparam int MAX_WINDOW_DEF   = 4;
	localparam int MAX_CHANNELS_DEF = 256;
	localparam int MAX_RESULTS      = 16;
	localparam int MAX_HEIGHT       = 1024;
	localparam int ROW_W            = 10;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 11;
	localparam int FLAT_W           = 28;

	localparam logic [CFG_IDX_W-1:0] REG_PLANE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_STRIDE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT    = 3'd6;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ORIG = 7'b0000010,
		ST_WIN  = 7'b0000100,
		ST_SCAN = 7'b0001000,
		ST_FIN  = 7'b0010000,
		ST_OUT  = 7'b0100000,
		ST_ADV  = 7'b1000000
	} mpa_state_t;

endpackage

// ===== rtl/core/max_pooling_with_argmax.sv =====
// Streaming 2-D max pooling with argmax over a line store, one comparator.
// Depends on mpa_pkg.
//
// channel  | direction | handshake          | payload
// pixel    | in        | in_valid/in_stall  | pixel
// result   | out       | out_valid/out_stall| max_value argmax_index out_col out_row
//          |           |                    | channel last_of_run
// config   | in        | cfg_we             | cfg_index cfg_data
//
// A pixel steps through ST_ORIG once per window offset and ST_WIN once per window index;
// every window it closes is scanned element by element in ST_SCAN, then ST_FIN and ST_OUT;
// one line-store read per cycle feeds the single comparator, and ST_ADV ends the pixel.
// in_stall is high from the accepted transfer until the pixel is fully done.
// A result waits in the output register while out_stall holds.
// Reset clears counters and control; the line store is not cleared.
module max_pooling_with_argmax
	import mpa_pkg::*;
#(
	parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
	parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [15:0]    pixel,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [15:0]    max_value,
	output logic [27:0]           argmax_index,
	output logic [9:0]            out_col,
	output logic [9:0]            out_row,
	output logic [7:0]            channel,
	output logic                  last_of_run,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int XW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int KW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int PW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNTW = $clog2(MAX_WINDOW + 1);
	localparam int EW   = $clog2(MAX_RESULTS + 1);
	localparam int CW   = 14;

	mpa_state_t state_q;

	logic [10:0] plane_width_q, plane_height_q, out_width_q, out_height_q;
	logic [8:0]  channel_count_q;
	logic [2:0]  pool_stride_q, window_size_q;

	logic [XW-1:0]    col_q, xq_q;
	logic [ROW_W-1:0] row_q, yq_q;
	logic [PW-1:0]    plane_q;
	logic [2:0]       cm_q, rm_q, xm_q, ym_q;
	logic [XW-1:0]    cq_q;
	logic [ROW_W-1:0] rq_q;
	logic [KW-1:0]    rslot_q, yslot_run_q;
	logic [FLAT_W-1:0] base_q, yb_run_q;

	logic [KW-1:0] k_q, jy_q, ix_q;
	logic [MAX_WINDOW-1:0] xv_q, yv_q;
	logic [XW-1:0]     xo_q [MAX_WINDOW];
	logic [XW-1:0]     xqa_q [MAX_WINDOW];
	logic [ROW_W-1:0]  yo_q [MAX_WINDOW];
	logic [ROW_W-1:0]  yqa_q [MAX_WINDOW];
	logic [KW-1:0]     ys_q [MAX_WINDOW];
	logic [FLAT_W-1:0] yb_q [MAX_WINDOW];
	logic [EW-1:0]     emit_q;

	logic [XW-1:0]     cc_q;
	logic [ROW_W-1:0]  rr_q;
	logic [KW-1:0]     slot_q;
	logic [FLAT_W-1:0] rb_q;
	logic              first_q;

	logic [15:0]       mem_q [MAX_WINDOW][MAX_WIDTH];
	logic [15:0]       rd_data_s1;
	logic [FLAT_W-1:0] flat_s1;
	logic              vld_s1, first_s1;
	logic signed [15:0] best_q;
	logic [FLAT_W-1:0]  bflat_q;

	logic [CW-1:0] w_c, h_c, chans_c;
	logic [KW-1:0] wsm1_c;
	logic [CW-1:0] ws_c;
	logic [2:0]    st_c;
	logic          x_ok, y_ok, in_xfer, out_free, win_take;
	logic [CNTW-1:0] nx_c, ny_c;
	logic [2*CNTW-1:0] tot_c;
	logic [EW-1:0] lim_c;
	logic          idx_done;
	logic [KW-1:0] jy_nx, ix_nx;

	always_comb begin
		w_c = CW'(plane_width_q);
		if (plane_width_q == 11'd0) w_c = CW'(1);
		else if (CW'(plane_width_q) > CW'(MAX_WIDTH)) w_c = CW'(MAX_WIDTH);
		h_c = CW'(plane_height_q);
		if (plane_height_q == 11'd0) h_c = CW'(1);
		else if (CW'(plane_height_q) > CW'(MAX_HEIGHT)) h_c = CW'(MAX_HEIGHT);
		chans_c = CW'(channel_count_q);
		if (channel_count_q == 9'd0) chans_c = CW'(1);
		else if (CW'(channel_count_q) > CW'(MAX_CHANNELS)) chans_c = CW'(MAX_CHANNELS);
		ws_c = CW'(window_size_q);
		if (window_size_q == 3'd0) ws_c = CW'(1);
		else if (CW'(window_size_q) > CW'(MAX_WINDOW)) ws_c = CW'(MAX_WINDOW);
		wsm1_c = KW'(ws_c - CW'(1));
		st_c = (pool_stride_q == 3'd0) ? 3'd1 : pool_stride_q;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		x_ok = (CW'(col_q) >= CW'(k_q)) && (xm_q == 3'd0)
			&& (CW'(xq_q) < CW'(out_width_q));
		if (CW'(col_q) + ws_c > w_c + CW'(k_q)) x_ok = x_ok && (CW'(col_q) == w_c - CW'(1));
		else x_ok = x_ok && (k_q == wsm1_c);
		y_ok = (CW'(row_q) >= CW'(k_q)) && (ym_q == 3'd0)
			&& (CW'(yq_q) < CW'(out_height_q));
		if (CW'(row_q) + ws_c > h_c + CW'(k_q)) y_ok = y_ok && (CW'(row_q) == h_c - CW'(1));
		else y_ok = y_ok && (k_q == wsm1_c);
	end

	always_comb begin
		nx_c = CNTW'($countones(xv_q));
		ny_c = CNTW'($countones(yv_q));
		tot_c = (2*CNTW)'(nx_c) * (2*CNTW)'(ny_c);
		lim_c = (CW'(tot_c) > CW'(MAX_RESULTS)) ? EW'(MAX_RESULTS) : EW'(tot_c);
		win_take = xv_q[ix_q] && yv_q[jy_q] && (CW'(emit_q) < CW'(MAX_RESULTS));
		idx_done = (ix_q == '0) && (jy_q == '0);
		jy_nx = jy_q;
		ix_nx = ix_q - KW'(1);
		if (ix_q == '0) begin
			ix_nx = wsm1_c;
			jy_nx = jy_q - KW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) mem_q[rslot_q][col_q] <= pixel;
		rd_data_s1 <= mem_q[slot_q][cc_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		flat_s1  <= rb_q + FLAT_W'(cc_q);
		first_s1 <= first_q;
		if (vld_s1 && (first_s1 || $signed(rd_data_s1) > best_q)) begin
			best_q  <= $signed(rd_data_s1);
			bflat_q <= flat_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			plane_width_q   <= 11'd32;
			plane_height_q  <= 11'd32;
			channel_count_q <= 9'd1;
			pool_stride_q   <= 3'd2;
			window_size_q   <= 3'd2;
			out_width_q     <= 11'd16;
			out_height_q    <= 11'd16;
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= '0;
			cm_q    <= '0;
			rm_q    <= '0;
			cq_q    <= '0;
			rq_q    <= '0;
			rslot_q <= '0;
			base_q  <= '0;
			out_valid <= 1'b0;
			xv_q    <= '0;
			yv_q    <= '0;
			emit_q  <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != ST_OUT) out_valid <= 1'b0;
			if (cfg_we && cfg_index <= REG_OUT_HEIGHT) begin
				case (cfg_index)
					REG_PLANE_WIDTH:   plane_width_q   <= cfg_data;
					REG_PLANE_HEIGHT:  plane_height_q  <= cfg_data;
					REG_CHANNEL_COUNT: channel_count_q <= cfg_data[8:0];
					REG_POOL_STRIDE:   pool_stride_q   <= cfg_data[2:0];
					REG_WINDOW_SIZE:   window_size_q   <= cfg_data[2:0];
					REG_OUT_WIDTH:     out_width_q     <= cfg_data;
					REG_OUT_HEIGHT:    out_height_q    <= cfg_data;
					default: ;
				endcase
				col_q   <= '0;
				row_q   <= '0;
				plane_q <= '0;
				cm_q    <= '0;
				rm_q    <= '0;
				cq_q    <= '0;
				rq_q    <= '0;
				rslot_q <= '0;
				base_q  <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						k_q  <= '0;
						xm_q <= cm_q;
						xq_q <= cq_q;
						ym_q <= rm_q;
						yq_q <= rq_q;
						yslot_run_q <= rslot_q;
						yb_run_q <= base_q;
						xv_q <= '0;
						yv_q <= '0;
						state_q <= ST_ORIG;
					end
				end
				ST_ORIG: begin
					xv_q[k_q]  <= x_ok;
					yv_q[k_q]  <= y_ok;
					xo_q[k_q]  <= col_q - XW'(k_q);
					xqa_q[k_q] <= xq_q;
					yo_q[k_q]  <= row_q - ROW_W'(k_q);
					yqa_q[k_q] <= yq_q;
					ys_q[k_q]  <= yslot_run_q;
					yb_q[k_q]  <= yb_run_q;
					xm_q <= (xm_q == 3'd0) ? st_c - 3'd1 : xm_q - 3'd1;
					xq_q <= (xm_q == 3'd0) ? xq_q - XW'(1) : xq_q;
					ym_q <= (ym_q == 3'd0) ? st_c - 3'd1 : ym_q - 3'd1;
					yq_q <= (ym_q == 3'd0) ? yq_q - ROW_W'(1) : yq_q;
					yslot_run_q <= (yslot_run_q == '0) ? KW'(MAX_WINDOW - 1)
						: yslot_run_q - KW'(1);
					yb_run_q <= yb_run_q - FLAT_W'(w_c);
					k_q <= k_q + KW'(1);
					if (k_q == wsm1_c) begin
						jy_q <= wsm1_c;
						ix_q <= wsm1_c;
						emit_q <= '0;
						state_q <= ST_WIN;
					end
				end
				ST_WIN: begin
					if (win_take) begin
						cc_q    <= xo_q[ix_q];
						rr_q    <= yo_q[jy_q];
						slot_q  <= ys_q[jy_q];
						rb_q    <= yb_q[jy_q];
						first_q <= 1'b1;
						state_q <= ST_SCAN;
					end else if (idx_done) begin
						state_q <= ST_ADV;
					end else begin
						jy_q <= jy_nx;
						ix_q <= ix_nx;
					end
				end
				ST_SCAN: begin
					first_q <= 1'b0;
					if (rr_q == row_q) begin
						if (cc_q == col_q) begin
							state_q <= ST_FIN;
						end else begin
							cc_q   <= cc_q + XW'(1);
							rr_q   <= yo_q[jy_q];
							slot_q <= ys_q[jy_q];
							rb_q   <= yb_q[jy_q];
						end
					end else begin
						rr_q   <= rr_q + ROW_W'(1);
						slot_q <= (slot_q == KW'(MAX_WINDOW - 1)) ? '0 : slot_q + KW'(1);
						rb_q   <= rb_q + FLAT_W'(w_c);
					end
				end
				ST_FIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid    <= 1'b1;
						max_value    <= best_q;
						argmax_index <= bflat_q;
						out_col      <= 10'(xqa_q[ix_q]);
						out_row      <= yqa_q[jy_q];
						channel      <= 8'(plane_q);
						last_of_run  <= (emit_q + EW'(1) == lim_c);
						emit_q       <= emit_q + EW'(1);
						if (idx_done) begin
							state_q <= ST_ADV;
						end else begin
							jy_q <= jy_nx;
							ix_q <= ix_nx;
							state_q <= ST_WIN;
						end
					end
				end
				ST_ADV: begin
					if (CW'(col_q) + CW'(1) >= w_c) begin
						col_q <= '0;
						cm_q  <= '0;
						cq_q  <= '0;
						if (CW'(row_q) + CW'(1) >= h_c) begin
							row_q   <= '0;
							rm_q    <= '0;
							rq_q    <= '0;
							rslot_q <= '0;
							if (CW'(plane_q) + CW'(1) >= chans_c) begin
								plane_q <= '0;
								base_q  <= '0;
							end else begin
								plane_q <= plane_q + PW'(1);
								base_q  <= base_q + FLAT_W'(w_c);
							end
						end else begin
							row_q   <= row_q + ROW_W'(1);
							rm_q    <= (rm_q + 3'd1 == st_c) ? 3'd0 : rm_q + 3'd1;
							rq_q    <= (rm_q + 3'd1 == st_c) ? rq_q + ROW_W'(1) : rq_q;
							rslot_q <= (rslot_q == KW'(MAX_WINDOW - 1)) ? '0
								: rslot_q + KW'(1);
							base_q  <= base_q + FLAT_W'(w_c);
						end
					end else begin
						col_q <= col_q + XW'(1);
						cm_q  <= (cm_q + 3'd1 == st_c) ? 3'd0 : cm_q + 3'd1;
						cq_q  <= (cm_q + 3'd1 == st_c) ? cq_q + XW'(1) : cq_q;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/mpa_checker.sv =====
// Port-level checks for max_pooling_with_argmax, attached by bind.
// No dependencies.
module mpa_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] max_value,
	input logic [27:0] argmax_index
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(max_value) && $stable(argmax_index))
		else $error("stalled result changed");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("ready right after a pixel transfer");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_stall)
		else $error("result appeared while idle");

endmodule

bind max_pooling_with_argmax mpa_port_checks u_mpa_port_checks (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.max_value    (max_value),
	.argmax_index (argmax_index)
);

// ===== verif/mpa_checker.sv =====
// Scoreboard for max_pooling_with_argmax: watches the pixel, result and register ports,
// predicts every window result and compares each result transfer field by field.
// Depends on mpa_pkg.
`timescale 1ns / 100ps

module mpa_checker
	import mpa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic signed [15:0]    pixel,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic signed [15:0]    max_value,
	input  logic [27:0]           argmax_index,
	input  logic [9:0]            out_col,
	input  logic [9:0]            out_row,
	input  logic [7:0]            channel,
	input  logic                  last_of_run,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending,
	output int                    checked
);

	typedef struct packed {
		logic signed [15:0] mx;
		logic [27:0]        idx;
		logic [9:0]         col;
		logic [9:0]         row;
		logic [7:0]         ch;
		logic               last;
	} pool_result_t;

	pool_result_t window_q[$];
	logic [15:0] line_mem [0:MAX_WIDTH_DEF*MAX_WINDOW_DEF-1];
	logic [10:0] r_width, r_height, r_outw, r_outh;
	logic [8:0]  r_chans;
	logic [2:0]  r_stride, r_wsize;
	int col_pos, row_pos, plane_pos;

	assign pending = window_q.size();

	function automatic int clampi(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	task automatic closing_origins(input int pos, input int ws, input int st, input int lim,
			input int outs, output int list [4], output int n);
		int lo, e;
		n = 0;
		lo = (pos + 1 >= ws) ? pos + 1 - ws : 0;
		for (int o = lo; o <= pos; o++) begin
			if (o % st != 0 || o / st >= outs)
				continue;
			e = (o + ws > lim) ? lim - 1 : o + ws - 1;
			if (e == pos && n < MAX_WINDOW_DEF) begin
				list[n] = o;
				n++;
			end
		end
	endtask

	task automatic pool_pixel(input logic [15:0] px);
		int w, h, chans, ws, st, c, r, nx, ny, n, brow, bcol;
		int xs [4];
		int ys [4];
		logic signed [15:0] best, v;
		bit have;
		longint flat;
		pool_result_t res;
		w = clampi(int'(r_width), 1, MAX_WIDTH_DEF);
		h = clampi(int'(r_height), 1, MAX_HEIGHT);
		chans = clampi(int'(r_chans), 1, MAX_CHANNELS_DEF);
		ws = clampi(int'(r_wsize), 1, MAX_WINDOW_DEF);
		st = (r_stride == 3'd0) ? 1 : int'(r_stride);
		c = (col_pos >= w) ? w - 1 : col_pos;
		r = (row_pos >= h) ? h - 1 : row_pos;
		n = 0;
		line_mem[(r % MAX_WINDOW_DEF) * MAX_WIDTH_DEF + c] = px;
		closing_origins(c, ws, st, w, int'(r_outw), xs, nx);
		closing_origins(r, ws, st, h, int'(r_outh), ys, ny);
		for (int j = 0; j < ny; j++) begin
			for (int i = 0; i < nx; i++) begin
				if (n >= MAX_RESULTS)
					continue;
				have = 0;
				best = 0;
				brow = ys[j];
				bcol = xs[i];
				for (int cc = xs[i]; cc <= c; cc++) begin
					for (int rr = ys[j]; rr <= r; rr++) begin
						v = line_mem[(rr % MAX_WINDOW_DEF) * MAX_WIDTH_DEF + cc];
						if (!have || v > best) begin
							have = 1;
							best = v;
							brow = rr;
							bcol = cc;
						end
					end
				end
				flat = longint'(plane_pos) * w * h + longint'(w) * brow + bcol;
				res.mx = best;
				res.idx = flat[27:0];
				res.col = 10'(xs[i] / st);
				res.row = 10'(ys[j] / st);
				res.ch = 8'(plane_pos);
				res.last = 0;
				window_q.push_back(res);
				n++;
			end
		end
		if (n > 0)
			window_q[window_q.size() - 1].last = 1;
		col_pos = c + 1;
		row_pos = r;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h) begin
				row_pos = 0;
				plane_pos++;
				if (plane_pos >= chans)
					plane_pos = 0;
			end
		end
	endtask

	task automatic check_result();
		pool_result_t e;
		if (window_q.size() == 0) begin
			$error("unexpected result transfer: max_value %0d argmax_index %0d",
				max_value, argmax_index);
			errors++;
			return;
		end
		e = window_q.pop_front();
		checked++;
		if (max_value !== e.mx) begin
			$error("max_value expected %0d actual %0d", e.mx, max_value);
			errors++;
		end
		if (argmax_index !== e.idx) begin
			$error("argmax_index expected %0d actual %0d", e.idx, argmax_index);
			errors++;
		end
		if (out_col !== e.col) begin
			$error("out_col expected %0d actual %0d", e.col, out_col);
			errors++;
		end
		if (out_row !== e.row) begin
			$error("out_row expected %0d actual %0d", e.row, out_row);
			errors++;
		end
		if (channel !== e.ch) begin
			$error("channel expected %0d actual %0d", e.ch, channel);
			errors++;
		end
		if (last_of_run !== e.last) begin
			$error("last_of_run expected %0d actual %0d", e.last, last_of_run);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_width = 11'd32;
			r_height = 11'd32;
			r_chans = 9'd1;
			r_stride = 3'd2;
			r_wsize = 3'd2;
			r_outw = 11'd16;
			r_outh = 11'd16;
			col_pos = 0;
			row_pos = 0;
			plane_pos = 0;
			window_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PLANE_WIDTH:   r_width = cfg_data;
					REG_PLANE_HEIGHT:  r_height = cfg_data;
					REG_CHANNEL_COUNT: r_chans = cfg_data[8:0];
					REG_POOL_STRIDE:   r_stride = cfg_data[2:0];
					REG_WINDOW_SIZE:   r_wsize = cfg_data[2:0];
					REG_OUT_WIDTH:     r_outw = cfg_data;
					REG_OUT_HEIGHT:    r_outh = cfg_data;
					default: ;
				endcase
				if (cfg_index <= REG_OUT_HEIGHT) begin
					col_pos = 0;
					row_pos = 0;
					plane_pos = 0;
				end
			end
			if (in_valid && !in_stall)
				pool_pixel(pixel);
			if (out_valid && !out_stall)
				check_result();
		end
	end

	initial begin
		errors = 0;
		checked = 0;
	end

endmodule

// ===== verif/tb_max_pooling_with_argmax.sv =====
// Top of the max_pooling_with_argmax testbench: clock, reset, register writes and pixel
// stimulus under several geometries and idle patterns; verdict from mpa_checker.
// Depends on mpa_pkg, max_pooling_with_argmax and mpa_checker.
`timescale 1ns / 100ps

module tb_max_pooling_with_argmax;
	import mpa_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 400;
	localparam int NUM_SETUPS = 9;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic signed [15:0] pixel = 0;
	logic out_stall = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_PLANE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = 0;
	logic in_stall, out_valid, last_of_run;
	logic signed [15:0] max_value;
	logic [27:0] argmax_index;
	logic [9:0] out_col, out_row;
	logic [7:0] channel;
	int errors, pending, checked;
	int cycles = 0;
	int sent = 0;
	int tx_idle = 0;
	int rx_idle = 0;

	// geometry per setup: width, height, planes, stride, window, out width, out height, pixels
	int g_w  [NUM_SETUPS] = '{3, 5, 0, 9, 4, 4, 2047, 6, 32};
	int g_h  [NUM_SETUPS] = '{3, 5, 7, 6, 4, 4, 2047, 4, 32};
	int g_ch [NUM_SETUPS] = '{2, 3, 0, 300, 1, 2, 511, 2, 1};
	int g_st [NUM_SETUPS] = '{1, 1, 0, 4, 2, 2, 3, 2, 2};
	int g_ws [NUM_SETUPS] = '{2, 4, 0, 7, 2, 2, 3, 3, 2};
	int g_ow [NUM_SETUPS] = '{3, 5, 1, 3, 0, 10, 2047, 3, 16};
	int g_oh [NUM_SETUPS] = '{3, 5, 7, 2, 4, 10, 2047, 2, 16};
	int g_n  [NUM_SETUPS] = '{18, 50, 60, 110, 20, 40, 40, 96, 70};

	logic signed [15:0] directed_px [18] = '{
		16'sh7FFF, -16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000, -16'sh0001,
		16'sh0005, 16'sh0005, 16'sh0005,
		-16'sh8000, -16'sh8000, -16'sh0001, -16'sh8000, -16'sh8000, -16'sh0100,
		16'sh0001, 16'sh0100, -16'sh8000};

	max_pooling_with_argmax uut (.*);

	mpa_checker chk (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < rx_idle);

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
	endtask

	task automatic wait_quiet();
		while (pending != 0 || in_stall)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_pixel(input logic signed [15:0] v);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		pixel <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	function automatic logic signed [15:0] rand_pixel();
		case ($urandom_range(9))
			0: return -16'sh8000;
			1: return 16'sh7FFF;
			2, 3: return 16'($signed($urandom_range(4)) - 2);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int s = 0; s < NUM_SETUPS; s++) begin
			if (s > 0)
				wait_quiet();
			write_reg(REG_PLANE_WIDTH, g_w[s]);
			write_reg(REG_PLANE_HEIGHT, g_h[s]);
			write_reg(REG_CHANNEL_COUNT, g_ch[s]);
			write_reg(REG_POOL_STRIDE, g_st[s]);
			write_reg(REG_WINDOW_SIZE, g_ws[s]);
			write_reg(REG_OUT_WIDTH, g_ow[s]);
			write_reg(REG_OUT_HEIGHT, g_oh[s]);
			cfg_we <= 0;
			@(posedge clk);
			for (int i = 0; i < g_n[s]; i++) begin
				if (sent < 200) begin
					tx_idle = 16;
					rx_idle = 87;
				end else if (sent < 400) begin
					tx_idle = 87;
					rx_idle = 16;
				end else begin
					tx_idle = 0;
					rx_idle = 0;
				end
				send_pixel((s == 0) ? directed_px[i] : rand_pixel());
			end
			in_valid <= 0;
		end
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d pixels across %0d geometries, %0d pooled results compared.",
			sent, NUM_SETUPS, checked);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/mpa_pkg.sv
rtl/core/max_pooling_with_argmax.sv
rtl/core/mpa_checker.sv
verif/mpa_checker.sv
verif/tb_max_pooling_with_argmax.sv
